/* rtl/lsp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsp_pkg: shared types and constants of the line sensor position unit
// payload structs, register indexes and the per-sensor weight table
// ---------------------------------------------------------------------------
package lsp_pkg;

   localparam int SENSOR_COUNT = 10;
   localparam int CAL_BITS     = 7;
   localparam int CSR_WIDTH    = 35;
   localparam int SCALE_FULL   = 100;

   typedef enum logic [2:0] {
      REG_WHITE_ON_BLACK = 3'd0,
      REG_THRESHOLD      = 3'd1,
      REG_RECOVERY_GAIN  = 3'd2,
      REG_CAL_MIN_LOW    = 3'd3,
      REG_CAL_MIN_HIGH   = 3'd4,
      REG_CAL_MAX_LOW    = 3'd5,
      REG_CAL_MAX_HIGH   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [11:0] sample_9;
      logic [11:0] sample_8;
      logic [11:0] sample_7;
      logic [11:0] sample_6;
      logic [11:0] sample_5;
      logic [11:0] sample_4;
      logic [11:0] sample_3;
      logic [11:0] sample_2;
      logic [11:0] sample_1;
      logic [11:0] sample_0;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] position;
      logic [9:0]         line_mask;
      logic [3:0]         active_count;
      logic               line_lost;
   } rsp_word_type;

   // classified frame handed from front to back
   typedef struct packed {
      logic [9:0]        line_mask;
      logic [3:0]        active_count;
      logic signed [4:0] weight_sum;
   } frame_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_DIV  = 2'd1,
      BK_OUT  = 2'd2
   } back_state_type;

   function automatic logic signed [3:0] sensor_weight(input int k);
      return (k < 5) ? 4'(k - 5) : 4'(k - 4);
   endfunction

endpackage

/* rtl/lsp_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsp_front: per-sensor scaling and thresholding
// walks the sensors one at a time through a shared restoring divider
// ---------------------------------------------------------------------------
module lsp_front import lsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   input  logic         white_on_black,
   input  logic [6:0]   threshold,
   input  logic [34:0]  cal_min_low,
   input  logic [34:0]  cal_min_high,
   input  logic [34:0]  cal_max_low,
   input  logic [34:0]  cal_max_high,
   output logic         frm_valid,
   input  logic         frm_full,
   output frame_type    frm_word
);

   logic               busy_ff, busy_in;
   logic [3:0]         sensor_ff, sensor_in;
   logic [2:0]         bit_ff, bit_in;
   logic [13:0]        rem_ff, rem_in;
   logic [6:0]         quo_ff, quo_in;
   req_word_type       samp_ff, samp_in;
   frame_type          acc_ff, acc_in;
   logic               done_ff, done_in;

   logic [11:0] raw;
   logic [6:0]  v, mn, mx, span;
   logic [13:0] dividend;
   logic        degen, last_bit;
   logic [7:0]  scaled;
   logic        act;
   logic [34:0] min_word, max_word;
   logic [2:0]  slot;
   logic [13:0] rcur, dsub, rsub;
   logic [6:0]  qcur, qbit_quo;
   logic        ovf;

   assign req_stall = busy_ff || done_ff;
   assign frm_valid = done_ff;
   assign frm_word  = acc_ff;

   always_comb begin
      raw      = samp_ff[12*sensor_ff +: 12];
      v        = raw[11:5];
      slot     = (sensor_ff < 4'd5) ? sensor_ff[2:0] : 3'(sensor_ff - 4'd5);
      min_word = (sensor_ff < 4'd5) ? cal_min_low : cal_min_high;
      max_word = (sensor_ff < 4'd5) ? cal_max_low : cal_max_high;
      mn       = min_word[7*slot +: 7];
      mx       = max_word[7*slot +: 7];
      degen    = (mx <= mn);
      span     = mx - mn;
      dividend = 14'((v > mn) ? (v - mn) : 7'd0) * 14'(SCALE_FULL);
      last_bit = (bit_ff == 3'd0);
      // one quotient bit per cycle, msb first; a new sensor starts from its dividend
      rcur     = (bit_ff == 3'd6) ? dividend : rem_ff;
      qcur     = (bit_ff == 3'd6) ? 7'd0 : quo_ff;
      dsub     = {7'd0, span} << bit_ff;
      qbit_quo = qcur;
      rsub     = rcur;
      if (rcur >= dsub) begin
         qbit_quo[bit_ff] = 1'b1;
         rsub             = rcur - dsub;
      end
      // quotients of 128 and up do not fit the 7-bit result and saturate anyway
      ovf = (dividend >= {span, 7'd0});
      if (degen) scaled = (v <= mn) ? 8'd0 : 8'(SCALE_FULL);
      else if (ovf || qbit_quo > 7'(SCALE_FULL)) scaled = 8'(SCALE_FULL);
      else scaled = {1'b0, qbit_quo};
      if (white_on_black) act = $signed({1'b0, scaled}) <
                                $signed(9'(SCALE_FULL) - {2'b0, threshold});
      else act = scaled > {1'b0, threshold};
   end

   always_comb begin
      busy_in   = busy_ff;
      sensor_in = sensor_ff;
      bit_in    = bit_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      samp_in   = samp_ff;
      acc_in    = acc_ff;
      done_in   = done_ff;
      if (done_ff && !frm_full) done_in = 1'b0;
      if (!busy_ff && !done_ff && req_valid) begin
         busy_in   = 1'b1;
         samp_in   = req_word;
         sensor_in = 4'd0;
         bit_in    = 3'd6;
         rem_in    = 14'd0;
         quo_in    = 7'd0;
         acc_in    = '0;
      end else if (busy_ff) begin
         rem_in = rsub;
         quo_in = qbit_quo;
         bit_in = bit_ff - 3'd1;
         if (last_bit) begin
            if (act) begin
               acc_in.line_mask[sensor_ff] = 1'b1;
               acc_in.active_count = acc_ff.active_count + 4'd1;
               acc_in.weight_sum   = acc_ff.weight_sum + 5'(sensor_weight(int'(sensor_ff)));
            end
            bit_in = 3'd6;
            if (sensor_ff == 4'(SENSOR_COUNT - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               sensor_in = sensor_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sensor_ff <= sensor_in;
      bit_ff    <= bit_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      samp_ff   <= samp_in;
      acc_ff    <= acc_in;
   end

endmodule

/* rtl/lsp_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsp_back: position computation
// serial signed divide of the weight sum, or gain scaling when the line is lost
// ---------------------------------------------------------------------------
module lsp_back import lsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         frm_valid,
   output logic         frm_full,
   input  frame_type    frm_word,
   input  logic [7:0]   recovery_gain,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   back_state_type     state_ff, state_in;
   frame_type          frm_ff, frm_in;
   logic [11:0]        mag_ff, mag_in;
   logic [11:0]        quo_ff, quo_in;
   logic [3:0]         step_ff, step_in;
   logic signed [11:0] last_ff, last_in;
   rsp_word_type       out_ff, out_in;

   logic [12:0]        trial;
   logic [11:0]        rem_next;
   logic signed [20:0] lost_prod;
   logic signed [15:0] lost_pos;
   logic               neg;

   always_comb begin
      frm_full  = (state_ff != BK_IDLE);
      rsp_valid = (state_ff == BK_OUT);
      rsp_word  = out_ff;
   end

   always_comb begin
      // magnitude 256*|wsum| <= 3840, one quotient bit per cycle
      trial    = {mag_ff[11:0], quo_ff[11]} - {9'd0, frm_ff.active_count};
      rem_next = trial[12] ? {mag_ff[10:0], quo_ff[11]} : trial[11:0];
      neg      = frm_ff.weight_sum[4];
      lost_prod = last_ff * $signed({1'b0, recovery_gain});
      lost_pos  = 16'((lost_prod + ((lost_prod < 0) ? 21'sd15 : 21'sd0)) >>> 4);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (frm_valid) state_in = (frm_word.active_count == 4'd0) ? BK_OUT : BK_DIV;
         BK_DIV:  if (step_ff == 4'd0) state_in = BK_OUT;
         BK_OUT:  if (!rsp_stall) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      frm_in  = frm_ff;
      mag_in  = mag_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      last_in = last_ff;
      out_in  = out_ff;
      unique case (state_ff)
         BK_IDLE: if (frm_valid) begin
            frm_in  = frm_word;
            mag_in  = 12'd0;
            // dividend bits ride in quo and shift out as quotient bits shift in
            quo_in  = {(frm_word.weight_sum[4] ? 4'(-frm_word.weight_sum) :
                        4'(frm_word.weight_sum)), 8'd0};
            step_in = 4'd11;
            if (frm_word.active_count == 4'd0) begin
               out_in.position     = lost_pos;
               out_in.line_mask    = frm_word.line_mask;
               out_in.active_count = 4'd0;
               out_in.line_lost    = 1'b1;
            end
         end
         BK_DIV: begin
            mag_in  = rem_next;
            quo_in  = {quo_ff[10:0], ~trial[12]};
            step_in = step_ff - 4'd1;
         end
         BK_OUT: ;
         default: ;
      endcase
      if (state_ff == BK_DIV && step_ff == 4'd0) begin
         out_in.position     = 16'(neg ? -$signed({1'b0, quo_in}) : $signed({1'b0, quo_in}));
         out_in.line_mask    = frm_ff.line_mask;
         out_in.active_count = frm_ff.active_count;
         out_in.line_lost    = 1'b0;
         last_in             = 12'(neg ? -$signed({1'b0, quo_in}) : $signed({1'b0, quo_in}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
      frm_ff  <= frm_in;
      mag_ff  <= mag_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      out_ff  <= out_in;
   end

endmodule

/* rtl/line_sensor_position_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_sensor_position_unit: ten-sensor line position
// scales and thresholds a frame, then forms the weighted mean position
// ---------------------------------------------------------------------------
//  channel | ports                        | direction
//  req     | req_valid req_stall req_word | in
//  rsp     | rsp_valid rsp_stall rsp_word | out
//  csr     | csr_write csr_index csr_data | in
//
// front: each sensor in turn goes through the shared scaling divider
// back: serial position divide, skipped when the line is lost
// the front takes the next frame while the back still works or is stalled
// synchronous reset restores register defaults and clears last position
module line_sensor_position_unit import lsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [34:0]  csr_data
);

   logic        wob_ff;
   logic [6:0]  thr_ff;
   logic [7:0]  gain_ff;
   logic [34:0] min_lo_ff, min_hi_ff, max_lo_ff, max_hi_ff;
   logic        frm_valid, frm_full;
   frame_type   frm_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         wob_ff    <= 1'b0;
         thr_ff    <= 7'd50;
         gain_ff   <= 8'd16;
         min_lo_ff <= '0;
         min_hi_ff <= '0;
         max_lo_ff <= '1;
         max_hi_ff <= '1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WHITE_ON_BLACK: wob_ff    <= csr_data[0];
            REG_THRESHOLD:      thr_ff    <= csr_data[6:0];
            REG_RECOVERY_GAIN:  gain_ff   <= csr_data[7:0];
            REG_CAL_MIN_LOW:    min_lo_ff <= csr_data;
            REG_CAL_MIN_HIGH:   min_hi_ff <= csr_data;
            REG_CAL_MAX_LOW:    max_lo_ff <= csr_data;
            REG_CAL_MAX_HIGH:   max_hi_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lsp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .white_on_black(wob_ff), .threshold(thr_ff),
      .cal_min_low(min_lo_ff), .cal_min_high(min_hi_ff),
      .cal_max_low(max_lo_ff), .cal_max_high(max_hi_ff),
      .frm_valid, .frm_full, .frm_word
   );

   lsp_back u_back (
      .clock, .reset, .frm_valid, .frm_full, .frm_word,
      .recovery_gain(gain_ff), .rsp_valid, .rsp_stall, .rsp_word
   );

   a_lost_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.line_lost == (rsp_word.active_count == 4'd0)))
      else $error("line_lost disagrees with active_count");
   a_count_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones(rsp_word.line_mask) == int'(rsp_word.active_count)))
      else $error("active_count disagrees with mask");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_word))
      else $error("stalled result changed");

endmodule
